// File: src/assert_macros.svh
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset
`define CHK_IMPLY(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Implication checked on every clock edge, reset included
`define CHK_ALWAYS(label, clk, cond, msg) \
    label: assert property (@(posedge clk) (cond)) else $error(msg);
`endif

// File: src/brlt_pkg.sv
// Shared types and constants for the byte-range lock table
package brlt_pkg;
    localparam int LOCK_SLOTS = 64;
    localparam int IDX_W = (LOCK_SLOTS > 1) ? $clog2(LOCK_SLOTS) : 1;
    localparam int CNT_W = $clog2(LOCK_SLOTS + 1);

    localparam logic [1:0] KIND_REQUEST = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_REL_ALL = 2'd2;
    localparam logic [1:0] KIND_QUERY   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_DENIED    = 2'd1;
    localparam logic [1:0] ST_NOT_HELD  = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] file_key;
        logic [63:0] session;
        logic [63:0] range_offset;
        logic [63:0] range_length;
        logic        want_exclusive;
        logic        for_write;
    } in_word_t;

    typedef struct packed {
        logic [1:0] status;
        logic       range_locked;
    } out_word_t;

    // Command handed from front end to table engine; range end precomputed
    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] file_key;
        logic [63:0] session;
        logic [63:0] range_offset;
        logic [63:0] range_length;
        logic [63:0] range_end;
        logic        zero_len;
        logic        excl;
        logic        wr;
    } cmd_t;

    function automatic logic [63:0] sat_end(input logic [63:0] off, input logic [63:0] len);
        logic [64:0] s;
        s = {1'b0, off} + {1'b0, len};
        return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
    endfunction
endpackage

// File: src/brlt_front.sv
// Front end: accepts input words, classifies them, and queues commands
module brlt_front import brlt_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  in_word_t in_word,
    input  logic     in_valid,
    output logic     in_stall,
    output cmd_t     cmd,
    output logic     cmd_valid,
    input  logic     cmd_take
);
    // two-entry queue
    cmd_t       q_reg [2];
    logic       rd_ptr_reg, rd_ptr_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       push, pop;
    cmd_t       c_in;

    assign in_stall  = (fill_reg == 2'd2);
    assign push      = in_valid && !in_stall;
    assign cmd_valid = (fill_reg != 2'd0);
    assign pop       = cmd_valid && cmd_take;
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        c_in.kind         = in_word.kind;
        c_in.file_key     = in_word.file_key;
        c_in.session      = in_word.session;
        c_in.range_offset = in_word.range_offset;
        c_in.range_length = in_word.range_length;
        c_in.range_end    = sat_end(in_word.range_offset, in_word.range_length);
        c_in.zero_len     = (in_word.range_length == 64'd0);
        c_in.excl         = in_word.want_exclusive;
        c_in.wr           = in_word.for_write;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= c_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            fill_reg   <= fill_next;
        end
    end
endmodule

// File: src/brlt_engine.sv
// Back end: scans and compacts the lock table, reading and checking one entry at a time
module brlt_engine import brlt_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_t      cmd,
    input  logic      cmd_valid,
    output logic      cmd_take,
    output out_word_t out_word,
    output logic      out_valid,
    input  logic      out_stall
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_DONE  = 3'd3;

    localparam int EW = 64 * 4 + 1;

    logic [EW-1:0] mem [LOCK_SLOTS];
    logic [EW-1:0] rd_data_reg;

    logic [2:0]       state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] keep_reg, keep_next;
    logic             hit_reg, hit_next;
    out_word_t        res_reg, res_next;
    logic             out_valid_reg, out_valid_next;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [EW-1:0]    wr_data;

    logic [63:0] e_file, e_sess, e_start, e_span, e_end;
    logic        e_excl, same_file, meet, match_rel, match_all;
    logic [CNT_W-1:0] last_idx;

    assign cmd_take  = (state_reg == S_IDLE) && cmd_valid;
    assign out_word  = res_reg;
    assign out_valid = out_valid_reg;

    assign {e_file, e_sess, e_start, e_span, e_excl} = rd_data_reg;

    always_comb
    begin
        e_end     = sat_end(e_start, e_span);
        same_file = (e_file == cmd_reg.file_key);
        meet      = !cmd_reg.zero_len && (e_span != 64'd0)
                    && (cmd_reg.range_offset < e_end) && (e_start < cmd_reg.range_end);
        match_rel = same_file && (e_sess == cmd_reg.session)
                    && (e_start == cmd_reg.range_offset) && (e_span == cmd_reg.range_length);
        match_all = same_file && (e_sess == cmd_reg.session);
        last_idx  = rd_reg - 1'b1;
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        count_next     = count_reg;
        rd_next        = rd_reg;
        keep_next      = keep_reg;
        hit_next       = hit_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        rd_en          = 1'b0;
        rd_addr        = rd_reg[IDX_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = keep_reg[IDX_W-1:0];
        wr_data        = rd_data_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    rd_next    = '0;
                    keep_next  = '0;
                    hit_next   = 1'b0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (rd_reg == count_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_next    = rd_reg + 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                // entry rd_reg-1 is now in rd_data_reg
                state_next = S_READ;
                unique case (cmd_reg.kind)
                    KIND_REQUEST:
                    begin
                        if (same_file && meet && (cmd_reg.excl || e_excl))
                        begin
                            hit_next   = 1'b1;
                            state_next = S_DONE;
                        end
                    end
                    KIND_QUERY:
                    begin
                        if (same_file && meet && (cmd_reg.wr || e_excl))
                        begin
                            hit_next   = 1'b1;
                            state_next = S_DONE;
                        end
                    end
                    KIND_RELEASE:
                    begin
                        // after the first match, shift the rest down one slot
                        if (hit_reg || !match_rel)
                        begin
                            if (keep_reg != last_idx)
                            begin
                                wr_en = 1'b1;
                            end
                            keep_next = keep_reg + 1'b1;
                        end
                        else
                        begin
                            hit_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (!match_all)
                        begin
                            if (keep_reg != last_idx)
                            begin
                                wr_en = 1'b1;
                            end
                            keep_next = keep_reg + 1'b1;
                        end
                    end
                endcase
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next        = 1'b1;
                    res_next.range_locked = 1'b0;
                    res_next.status       = ST_OK;
                    state_next            = S_IDLE;
                    unique case (cmd_reg.kind)
                        KIND_REQUEST:
                        begin
                            if (hit_reg)
                            begin
                                res_next.status = ST_DENIED;
                            end
                            else if (count_reg >= CNT_W'(LOCK_SLOTS))
                            begin
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = count_reg[IDX_W-1:0];
                                wr_data    = {cmd_reg.file_key, cmd_reg.session,
                                              cmd_reg.range_offset, cmd_reg.range_length,
                                              cmd_reg.excl};
                                count_next = count_reg + 1'b1;
                            end
                        end
                        KIND_RELEASE:
                        begin
                            if (hit_reg)
                            begin
                                count_next = keep_reg;
                            end
                            else
                            begin
                                res_next.status = ST_NOT_HELD;
                            end
                        end
                        KIND_REL_ALL:
                        begin
                            count_next = keep_reg;
                        end
                        KIND_QUERY:
                        begin
                            res_next.range_locked = hit_reg;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        cmd_reg <= cmd_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rd_reg        <= '0;
            keep_reg      <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_reg        <= rd_next;
            keep_reg      <= keep_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

// File: src/byte_range_lock_table.sv
// Each input word is answered after a scan of the locks held (up to 64); the engine takes
// no new word from its queue until the result of the last one is registered at the output.
// The table engine reads and checks one entry at a time from the table memory;
// requests and queries stop scanning at the first conflicting entry.
// A two-word command queue lets the input side keep taking words while a scan runs.
// Reset (rst_n, async low) empties the table and queues; no clearing pass is needed.
module byte_range_lock_table import brlt_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  in_word_t  in_word,
    input  logic      in_valid,
    output logic      in_stall,
    output out_word_t out_word,
    output logic      out_valid,
    input  logic      out_stall
);
    cmd_t cmd;
    logic cmd_valid;
    logic cmd_take;

    brlt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_word  (in_word),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .cmd_valid(cmd_valid),
        .cmd_take (cmd_take)
    );

    brlt_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cmd_valid(cmd_valid),
        .cmd_take (cmd_take),
        .out_word (out_word),
        .out_valid(out_valid),
        .out_stall(out_stall)
    );
endmodule

// File: src/brlt_checker.sv
// Port-level checker for the lock table, bound to the top level
`include "assert_macros.svh"
module brlt_checker import brlt_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    input in_word_t  in_word,
    input logic      in_valid,
    input logic      in_stall,
    input out_word_t out_word,
    input logic      out_valid,
    input logic      out_stall
);
    `CHK_IMPLY(a_out_hold, clk, rst_n,
        (out_valid && out_stall) |=> (out_valid && $stable(out_word)),
        "result dropped or changed while stalled")
    `CHK_IMPLY(a_lock_only_ok, clk, rst_n,
        (out_valid && out_word.range_locked) |-> (out_word.status == ST_OK),
        "locked flag on non-query status")
    `CHK_ALWAYS(a_reset_idle, clk, !rst_n |-> (!out_valid && !in_stall),
        "outputs active in reset")
    `CHK_IMPLY(a_in_hold, clk, rst_n,
        (in_valid && in_stall) |=> (in_valid && $stable(in_word)),
        "input word dropped or changed while stalled")
endmodule

bind byte_range_lock_table brlt_checker u_brlt_checker (.*);

// File: tb/sv/tb_top.sv
// Self-checking testbench for the byte-range lock table
`timescale 1ns / 100ps

module tb_top;
    import brlt_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        in_word_t  w;
        bit        typed;
        out_word_t want;
    } vec_t;

    logic      clk;
    logic      rst_n;
    in_word_t  in_word;
    logic      in_valid;
    logic      in_stall;
    out_word_t out_word;
    logic      out_valid;
    logic      out_stall;

    // lock table mirror
    logic [63:0] lk_file [LOCK_SLOTS];
    logic [63:0] lk_sess [LOCK_SLOTS];
    logic [63:0] lk_start [LOCK_SLOTS];
    logic [63:0] lk_span [LOCK_SLOTS];
    logic        lk_excl [LOCK_SLOTS];
    int          lock_count;

    out_word_t pending_status[$];
    int        mismatches;
    int        words_sent;
    int        words_seen;
    int        full_hits;
    int        denials;
    int        send_idle_pct;
    int        stall_pct;
    bit        hold_go;
    int        hold_left;
    int        quiet_cycles;
    vec_t      directed[$];

    byte_range_lock_table uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_word(in_word),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .out_word(out_word),
        .out_valid(out_valid),
        .out_stall(out_stall)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic logic [63:0] sat_span_end(logic [63:0] off, logic [63:0] len);
        logic [64:0] sum;
        sum = {1'b0, off} + {1'b0, len};
        return sum[64] ? '1 : sum[63:0];
    endfunction

    function automatic bit spans_meet(logic [63:0] o1, logic [63:0] l1,
                                      logic [63:0] o2, logic [63:0] l2);
        if (l1 == 0 || l2 == 0)
            return 0;
        return (o1 < sat_span_end(o2, l2)) && (o2 < sat_span_end(o1, l1));
    endfunction

    // apply one word to the mirror and return the status it should produce
    function automatic out_word_t lock_table_step(in_word_t w);
        out_word_t r;
        int keep;
        r = '0;
        case (w.kind)
            KIND_REQUEST:
            begin
                for (int i = 0; i < lock_count; i++)
                begin
                    if (r.status == ST_OK && lk_file[i] == w.file_key &&
                        spans_meet(w.range_offset, w.range_length, lk_start[i], lk_span[i]) &&
                        (w.want_exclusive || lk_excl[i]))
                        r.status = ST_DENIED;
                end
                if (r.status == ST_OK)
                begin
                    if (lock_count >= LOCK_SLOTS)
                        r.status = ST_FULL;
                    else
                    begin
                        lk_file[lock_count] = w.file_key;
                        lk_sess[lock_count] = w.session;
                        lk_start[lock_count] = w.range_offset;
                        lk_span[lock_count] = w.range_length;
                        lk_excl[lock_count] = w.want_exclusive;
                        lock_count++;
                    end
                end
            end
            KIND_RELEASE:
            begin
                r.status = ST_NOT_HELD;
                for (int i = 0; i < lock_count; i++)
                begin
                    if (lk_file[i] == w.file_key && lk_sess[i] == w.session &&
                        lk_start[i] == w.range_offset && lk_span[i] == w.range_length)
                    begin
                        for (int j = i; j + 1 < lock_count; j++)
                        begin
                            lk_file[j] = lk_file[j+1];
                            lk_sess[j] = lk_sess[j+1];
                            lk_start[j] = lk_start[j+1];
                            lk_span[j] = lk_span[j+1];
                            lk_excl[j] = lk_excl[j+1];
                        end
                        lock_count--;
                        r.status = ST_OK;
                        break;
                    end
                end
            end
            KIND_REL_ALL:
            begin
                keep = 0;
                for (int i = 0; i < lock_count; i++)
                begin
                    if (!(lk_file[i] == w.file_key && lk_sess[i] == w.session))
                    begin
                        lk_file[keep] = lk_file[i];
                        lk_sess[keep] = lk_sess[i];
                        lk_start[keep] = lk_start[i];
                        lk_span[keep] = lk_span[i];
                        lk_excl[keep] = lk_excl[i];
                        keep++;
                    end
                end
                lock_count = keep;
            end
            default:
            begin
                for (int i = 0; i < lock_count; i++)
                begin
                    if (lk_file[i] == w.file_key &&
                        spans_meet(w.range_offset, w.range_length, lk_start[i], lk_span[i]) &&
                        (lk_excl[i] || w.for_write))
                        r.range_locked = 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    function automatic in_word_t mk(logic [1:0] kind, logic [63:0] f, logic [63:0] s,
                                    logic [63:0] o, logic [63:0] l, logic x, logic wr);
        in_word_t w;
        w.kind = kind;
        w.file_key = f;
        w.session = s;
        w.range_offset = o;
        w.range_length = l;
        w.want_exclusive = x;
        w.for_write = wr;
        return w;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick_offset();
        int r;
        r = $urandom_range(99);
        if (r < 65)
            return $urandom_range(255);
        else if (r < 80)
            return 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(255);
        return rand64();
    endfunction

    function automatic logic [63:0] pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return '0;
        else if (r < 70)
            return $urandom_range(1, 64);
        else if (r < 82)
            return '1;
        return rand64();
    endfunction

    function automatic in_word_t random_word();
        in_word_t w;
        int idx;
        int r;
        w = mk($urandom_range(3), $urandom_range(3), $urandom_range(3),
               pick_offset(), pick_length(), $urandom_range(1), $urandom_range(1));
        if ($urandom_range(99) < 10)
            w.file_key = rand64();
        if ($urandom_range(99) < 10)
            w.session = rand64();
        r = $urandom_range(99);
        if (r < 40)
            w.kind = KIND_REQUEST;
        else if (r < 65)
            w.kind = KIND_RELEASE;
        else if (r < 72)
            w.kind = KIND_REL_ALL;
        else
            w.kind = KIND_QUERY;
        // most releases name a lock that is held
        if (w.kind == KIND_RELEASE && lock_count > 0 && $urandom_range(99) < 70)
        begin
            idx = $urandom_range(lock_count - 1);
            w.file_key = lk_file[idx];
            w.session = lk_sess[idx];
            w.range_offset = lk_start[idx];
            w.range_length = lk_span[idx];
        end
        return w;
    endfunction

    task automatic send_word(in_word_t w, bit typed, out_word_t want);
        out_word_t got;
        in_word <= w;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        got = lock_table_step(w);
        if (typed)
            got = want;
        if (w.kind == KIND_REQUEST && got.status == ST_FULL)
            full_hits++;
        if (w.kind == KIND_REQUEST && got.status == ST_DENIED)
            denials++;
        pending_status = {pending_status, got};
        words_sent++;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_phase(int count, int idle_pct, int stall);
        send_idle_pct = idle_pct;
        stall_pct = stall;
        repeat (count) send_word(random_word(), 0, '0);
        drain();
    endtask

    // fill one file with shared locks until the table overflows, then empty it
    task automatic fill_phase();
        send_idle_pct = 0;
        stall_pct = 17;
        for (int i = 0; i < LOCK_SLOTS + 6; i++)
            send_word(mk(KIND_REQUEST, 64'd7, 64'd9, $urandom_range(1000),
                         $urandom_range(1, 100), 1'b0, 1'b0), 0, '0);
        send_word(mk(KIND_REL_ALL, 64'd7, 64'd9, 0, 0, 1'b0, 1'b0), 0, '0);
        drain();
    endtask

    // receiver: random stalls, with a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_go)
        begin
            hold_go = 1'b0;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            words_seen++;
            if (pending_status.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: status %0d locked %0d",
                             out_word.status, out_word.range_locked);
            end
            else
            begin
                want = pending_status.pop_front();
                if (out_word.status !== want.status ||
                    out_word.range_locked !== want.range_locked)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("word %0d: expected status %0d locked %0d, got %0d %0d",
                                 words_seen, want.status, want.range_locked,
                                 out_word.status, out_word.range_locked);
                end
            end
        end
    end

    // watchdog: ends the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("byte_range_lock_table verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        logic [63:0] top;
        top = '1;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        hold_go = 1'b0;
        quiet_cycles = 0;
        mismatches = 0;
        words_sent = 0;
        words_seen = 0;
        full_hits = 0;
        denials = 0;
        lock_count = 0;
        send_idle_pct = 0;
        stall_pct = 0;

        // kind, file, session, offset, length, excl, write; typed flag; expected status, locked
        directed = '{
            '{mk(KIND_QUERY,   1, 10, 0, 100, 0, 1), 1, '{ST_OK, 1'b0}},
            '{mk(KIND_RELEASE, 1, 10, 0, 10, 0, 0),  1, '{ST_NOT_HELD, 1'b0}},
            '{mk(KIND_REQUEST, 1, 10, 0, 100, 1, 0), 1, '{ST_OK, 1'b0}},
            '{mk(KIND_REQUEST, 1, 20, 50, 10, 0, 0), 1, '{ST_DENIED, 1'b0}},
            '{mk(KIND_REQUEST, 1, 20, 100, 10, 1, 0), 1, '{ST_OK, 1'b0}},
            '{mk(KIND_QUERY,   1, 20, 99, 1, 0, 0),  1, '{ST_OK, 1'b1}},
            '{mk(KIND_QUERY,   1, 10, 0, 0, 0, 1),   1, '{ST_OK, 1'b0}},
            '{mk(KIND_REQUEST, 1, 20, 0, 0, 1, 0),   1, '{ST_OK, 1'b0}},
            '{mk(KIND_REQUEST, 2, 10, top - 15, top, 1, 0), 1, '{ST_OK, 1'b0}},
            '{mk(KIND_QUERY,   2, 20, top, 1, 0, 0), 1, '{ST_OK, 1'b0}},
            '{mk(KIND_QUERY,   2, 20, top - 1, 1, 0, 0), 1, '{ST_OK, 1'b1}},
            '{mk(KIND_REQUEST, 2, 20, 0, top, 0, 0), 1, '{ST_DENIED, 1'b0}},
            '{mk(KIND_REQUEST, 3, 10, 10, 10, 0, 0), 1, '{ST_OK, 1'b0}},
            '{mk(KIND_REQUEST, 3, 20, 15, 10, 0, 0), 1, '{ST_OK, 1'b0}},
            '{mk(KIND_QUERY,   3, 30, 12, 1, 0, 0),  1, '{ST_OK, 1'b0}},
            '{mk(KIND_QUERY,   3, 30, 12, 1, 0, 1),  1, '{ST_OK, 1'b1}},
            '{mk(KIND_RELEASE, 1, 10, 0, 100, 0, 0), 1, '{ST_OK, 1'b0}},
            '{mk(KIND_RELEASE, 1, 10, 0, 100, 0, 0), 1, '{ST_NOT_HELD, 1'b0}},
            '{mk(KIND_REL_ALL, 3, 10, 0, 0, 0, 0),   1, '{ST_OK, 1'b0}},
            '{mk(KIND_REL_ALL, 9, 9, 0, 0, 0, 0),    1, '{ST_OK, 1'b0}},
            '{mk(KIND_QUERY,   top, top, top, top, 1, 1), 1, '{ST_OK, 1'b0}},
            '{mk(KIND_REQUEST, top, top, 0, top, 1, 1),   1, '{ST_OK, 1'b0}},
            '{mk(KIND_REQUEST, top, 5, top, top, 0, 1),   0, '{ST_OK, 1'b0}},
            '{mk(KIND_REL_ALL, top, top, top, top, 1, 1), 1, '{ST_OK, 1'b0}}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_word(directed[i].w, directed[i].typed, directed[i].want);
        drain();

        random_phase(140, 0, 0);
        fill_phase();
        random_phase(140, 59, 0);
        random_phase(140, 0, 59);

        // long receiver hold-off while the sender keeps pushing
        send_idle_pct = 0;
        stall_pct = 0;
        hold_go = 1'b1;
        repeat (40) send_word(random_word(), 0, '0);
        drain();

        random_phase(150, 17, 17);

        in_valid <= 1'b0;
        repeat (200) @(posedge clk);

        $display("%0d words sent, %0d results checked, %0d denials, %0d table-full hits",
                 words_sent, words_seen, denials, full_hits);
        if (mismatches == 0 && pending_status.size() == 0)
            $display("byte_range_lock_table verification clean");
        else
        begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     pending_status.size());
            $display("byte_range_lock_table verification failed");
        end
        $finish;
    end
endmodule

// File: files.f
+incdir+src
src/brlt_pkg.sv
src/brlt_front.sv
src/brlt_engine.sv
src/byte_range_lock_table.sv
src/brlt_checker.sv
tb/sv/tb_top.sv
